[src/spdf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdf_pkg
// Shared types and constants for the short packet deframer.
// ----------------------------------------------------------------------------
package spdf_pkg;

  localparam logic [7:0]  START_BYTE = 8'h02;
  localparam logic [7:0]  END_BYTE   = 8'h03;
  localparam logic [15:0] CRC_TOP    = 16'h8000;

  localparam logic [15:0] CRC_POLY_RST   = 16'h1021;
  localparam logic [15:0] CRC_INIT_RST   = 16'h0000;
  localparam logic [7:0]  HUNT_LIMIT_RST = 8'd100;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'd0,
    PH_LEN     = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_CRC_HI  = 3'd3,
    PH_CRC_LO  = 3'd4,
    PH_END     = 3'd5
  } phase_t;

  typedef enum logic [2:0] {
    K_DATA      = 3'd0,
    K_GOOD      = 3'd1,
    K_BAD_CRC   = 3'd2,
    K_BAD_END   = 3'd3,
    K_SYNC_LOST = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    REG_CRC_POLY   = 2'd0,
    REG_CRC_INIT   = 2'd1,
    REG_HUNT_LIMIT = 2'd2
  } reg_idx_t;

endpackage

[src/spdf_crc8.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spdf_crc8
// One-byte CRC-16 update, MSB first, with a programmable polynomial.
// ----------------------------------------------------------------------------
module spdf_crc8 (
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  input  logic [15:0] poly,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & spdf_pkg::CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ poly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

[src/short_packet_deframer_crc16.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// short_packet_deframer_crc16
// Hunts for framed packets in a byte stream, passes payload bytes on and
// reports one status per frame after checking the end byte and CRC-16, and sync loss while hunting.
// ----------------------------------------------------------------------------
// Output is registered: a result appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle while a held result is not stalled; the
// byte-wide CRC update is combinational XOR logic feeding the frame state.
// Reset: synchronous, active low; phase returns to hunting, counters and CRC
// clear, and the registers take 0x1021 / 0x0000 / 100.
module short_packet_deframer_crc16 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_frame_length,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  spdf_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  length_seen_r, length_seen_nxt;
  logic [15:0] crc_running_r, crc_running_nxt;
  logic [15:0] crc_taken_r, crc_taken_nxt;
  logic [7:0]  hunt_count_r, hunt_count_nxt;

  logic [15:0] crc_poly_r, crc_init_r;
  logic [7:0]  hunt_limit_r;

  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_kind_r, out_kind_nxt;
  logic [7:0]  out_data_r, out_data_nxt;
  logic [7:0]  out_len_r, out_len_nxt;

  logic        in_xfer;
  logic        res_valid;
  spdf_pkg::kind_t res_kind;
  logic [7:0]  res_data;
  logic [7:0]  res_len;
  logic [15:0] crc_upd;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign in_xfer   = in_valid & ~in_stall;

  spdf_crc8 u_crc (
    .crc_in  (crc_running_r),
    .data    (in_rx_byte),
    .poly    (crc_poly_r),
    .crc_out (crc_upd)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_poly_r   <= spdf_pkg::CRC_POLY_RST;
      crc_init_r   <= spdf_pkg::CRC_INIT_RST;
      hunt_limit_r <= spdf_pkg::HUNT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        spdf_pkg::REG_CRC_POLY:   crc_poly_r   <= cfg_data;
        spdf_pkg::REG_CRC_INIT:   crc_init_r   <= cfg_data;
        spdf_pkg::REG_HUNT_LIMIT: hunt_limit_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= spdf_pkg::PH_HUNT;
      bytes_left_r  <= 8'd0;
      length_seen_r <= 8'd0;
      crc_running_r <= 16'd0;
      crc_taken_r   <= 16'd0;
      hunt_count_r  <= 8'd0;
    end else begin
      phase_r       <= phase_nxt;
      bytes_left_r  <= bytes_left_nxt;
      length_seen_r <= length_seen_nxt;
      crc_running_r <= crc_running_nxt;
      crc_taken_r   <= crc_taken_nxt;
      hunt_count_r  <= hunt_count_nxt;
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    bytes_left_nxt  = bytes_left_r;
    length_seen_nxt = length_seen_r;
    crc_running_nxt = crc_running_r;
    crc_taken_nxt   = crc_taken_r;
    hunt_count_nxt  = hunt_count_r;
    res_valid       = 1'b0;
    res_kind        = spdf_pkg::K_DATA;
    res_data        = 8'd0;
    res_len         = 8'd0;

    if (in_xfer) begin
      case (phase_r)
        spdf_pkg::PH_LEN: begin
          length_seen_nxt = in_rx_byte;
          bytes_left_nxt  = in_rx_byte;
          phase_nxt = (in_rx_byte == 8'd0) ? spdf_pkg::PH_CRC_HI : spdf_pkg::PH_PAYLOAD;
        end
        spdf_pkg::PH_PAYLOAD: begin
          crc_running_nxt = crc_upd;
          bytes_left_nxt  = bytes_left_r - 8'd1;
          if (bytes_left_r == 8'd1) begin
            phase_nxt = spdf_pkg::PH_CRC_HI;
          end
          res_valid = 1'b1;
          res_kind  = spdf_pkg::K_DATA;
          res_data  = in_rx_byte;
        end
        spdf_pkg::PH_CRC_HI: begin
          crc_taken_nxt = {in_rx_byte, 8'h00};
          phase_nxt     = spdf_pkg::PH_CRC_LO;
        end
        spdf_pkg::PH_CRC_LO: begin
          crc_taken_nxt = {crc_taken_r[15:8], in_rx_byte};
          phase_nxt     = spdf_pkg::PH_END;
        end
        spdf_pkg::PH_END: begin
          // End byte is checked before the CRC
          if (in_rx_byte != spdf_pkg::END_BYTE) begin
            res_kind = spdf_pkg::K_BAD_END;
          end else if (crc_taken_r != crc_running_r) begin
            res_kind = spdf_pkg::K_BAD_CRC;
          end else begin
            res_kind = spdf_pkg::K_GOOD;
          end
          res_valid      = 1'b1;
          res_len        = length_seen_r;
          phase_nxt      = spdf_pkg::PH_HUNT;
          hunt_count_nxt = 8'd0;
        end
        default: begin
          phase_nxt = spdf_pkg::PH_HUNT;
          if (hunt_count_r >= hunt_limit_r) begin
            // Limit hit: report sync lost, even on a start byte
            hunt_count_nxt = 8'd0;
            res_valid      = 1'b1;
            res_kind       = spdf_pkg::K_SYNC_LOST;
          end else if (in_rx_byte == spdf_pkg::START_BYTE) begin
            hunt_count_nxt  = 8'd0;
            crc_running_nxt = crc_init_r;
            phase_nxt       = spdf_pkg::PH_LEN;
          end else begin
            hunt_count_nxt = hunt_count_r + 8'd1;
          end
        end
      endcase
    end
  end

  // Result register: load on a transfer, drop once the consumer takes it
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_data_nxt  = out_data_r;
    out_len_nxt   = out_len_r;
    if (in_xfer) begin
      out_valid_nxt = res_valid;
      out_kind_nxt  = res_kind;
      out_data_nxt  = res_data;
      out_len_nxt   = res_len;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_data_r <= out_data_nxt;
    out_len_r  <= out_len_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_data_byte    = out_data_r;
  assign out_frame_length = out_len_r;

endmodule

[bench/frame_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_checker
// Watches the byte, result and register channels of the deframer, predicts
// each result from the accepted bytes and compares the result stream with
// the prediction field by field.
// ----------------------------------------------------------------------------
module frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_kind,
  input  logic [7:0]  out_data_byte,
  input  logic [7:0]  out_frame_length,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);
  import spdf_pkg::*;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] len;
  } frame_result_t;

  frame_result_t due_results [$];

  // register copies
  logic [15:0] poly;
  logic [15:0] crc_seed;
  logic [7:0]  limit;

  // deframer state copy
  phase_t      ph;
  logic [7:0]  remaining;
  logic [7:0]  frame_len;
  logic [7:0]  hunted;
  logic [15:0] crc_acc;
  logic [15:0] crc_rx;

  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b,
                                             input logic [15:0] gen);
    logic [15:0] c;
    int          i;
    c = crc ^ {b, 8'h00};
    for (i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) c = (c << 1) ^ gen;
      else c = c << 1;
    end
    return c;
  endfunction

  task automatic push_result(input kind_t k, input logic [7:0] d, input logic [7:0] l);
    frame_result_t r;
    r.kind = k;
    r.data = d;
    r.len  = l;
    due_results = {due_results, r};
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    kind_t k;
    case (ph)
      PH_LEN: begin
        frame_len = b;
        remaining = b;
        if (b == 8'h00) ph = PH_CRC_HI;
        else ph = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        crc_acc   = crc16_step(crc_acc, b, poly);
        remaining = remaining - 8'd1;
        if (remaining == 8'h00) ph = PH_CRC_HI;
        push_result(K_DATA, b, 8'h00);
      end
      PH_CRC_HI: begin
        crc_rx = {b, 8'h00};
        ph     = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        crc_rx[7:0] = b;
        ph          = PH_END;
      end
      PH_END: begin
        // end byte is judged before the CRC
        if (b != END_BYTE) k = K_BAD_END;
        else if (crc_rx != crc_acc) k = K_BAD_CRC;
        else k = K_GOOD;
        ph     = PH_HUNT;
        hunted = 8'h00;
        push_result(k, 8'h00, frame_len);
      end
      default: begin
        ph = PH_HUNT;
        if (hunted >= limit) begin
          hunted = 8'h00;
          push_result(K_SYNC_LOST, 8'h00, 8'h00);
        end else begin
          hunted = hunted + 8'd1;
          if (b == START_BYTE) begin
            hunted  = 8'h00;
            crc_acc = crc_seed;
            ph      = PH_LEN;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      poly         = CRC_POLY_RST;
      crc_seed     = CRC_INIT_RST;
      limit        = HUNT_LIMIT_RST;
      ph           = PH_HUNT;
      remaining    = 8'h00;
      frame_len    = 8'h00;
      hunted       = 8'h00;
      crc_acc      = 16'h0000;
      crc_rx       = 16'h0000;
      fail_count   = 0;
      results_seen = 0;
      due_results.delete();
    end else begin
      // retire the result first: it always stems from an earlier byte
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_results.size() == 0) begin
          $error("unexpected result: kind %0d data_byte %0h frame_length %0d",
                 out_kind, out_data_byte, out_frame_length);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          if (out_kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_kind);
            fail_count++;
          end
          if (out_data_byte !== want.data) begin
            $error("data_byte: expected %0h, actual %0h", want.data, out_data_byte);
            fail_count++;
          end
          if (out_frame_length !== want.len) begin
            $error("frame_length: expected %0d, actual %0d", want.len, out_frame_length);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CRC_POLY:   poly = cfg_data;
          REG_CRC_INIT:   crc_seed = cfg_data;
          REG_HUNT_LIMIT: limit = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) deframe_byte(in_rx_byte);
    end
    pending <= due_results.size();
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Feeds the deframer directed frames and then phases of random frames, noise
// and truncated frames under changing CRC and hunt settings, with random
// gaps and back-pressure; the checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb_top;
  import spdf_pkg::*;

  localparam int         ITEM_TARGET    = 1800;
  localparam int         LONG_HOLD      = 250;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         NO_CUT         = 1000;
  localparam logic [1:0] REG_UNUSED     = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [7:0]  out_frame_length;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int fail_count;
  int pending;
  int results_seen;

  bit          no_idle;
  bit          hold_req;
  logic [15:0] cur_poly;
  logic [15:0] cur_init;
  logic [7:0]  pl [256];
  logic [7:0]  frame_buf [261];
  int          bytes_sent;
  int          frame_bytes;
  int          frames_sent;
  int          cfg_writes;
  int          phases;

  always #5 clk = ~clk;

  short_packet_deframer_crc16 uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_frame_length (out_frame_length),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  frame_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_frame_length (out_frame_length),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .pending          (pending),
    .results_seen     (results_seen)
  );

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r == 0) return 255;
    if (r < 5) return $urandom_range(16, 64);
    return $urandom_range(0, 8);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // payload comes from pl; crc_flip corrupts the sent CRC, cut truncates the frame
  task automatic send_frame(input int len, input logic [15:0] crc_flip,
                            input logic [7:0] end_byte, input int cut);
    logic [15:0] crc;
    int          total;
    int          i;
    int          j;
    crc          = cur_init;
    frame_buf[0] = START_BYTE;
    frame_buf[1] = 8'(len);
    for (i = 0; i < len; i++) begin
      frame_buf[i + 2] = pl[i];
      crc = crc ^ {pl[i], 8'h00};
      for (j = 0; j < 8; j++) begin
        if (crc[15]) crc = (crc << 1) ^ cur_poly;
        else crc = crc << 1;
      end
    end
    crc = crc ^ crc_flip;
    frame_buf[len + 2] = crc[15:8];
    frame_buf[len + 3] = crc[7:0];
    frame_buf[len + 4] = end_byte;
    total = (cut < len + 5) ? cut : len + 5;
    for (i = 0; i < total; i++) send_byte(frame_buf[i]);
    frame_bytes += total;
    frames_sent++;
  endtask

  task automatic fill_payload(input int len);
    int i;
    for (i = 0; i < len; i++) begin
      case ($urandom_range(0, 11))
        0:       pl[i] = START_BYTE;
        1:       pl[i] = END_BYTE;
        default: pl[i] = 8'($urandom);
      endcase
    end
  endtask

  // hold the sender until every predicted result has been taken
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    if (idx == REG_CRC_POLY) cur_poly = d;
    else if (idx == REG_CRC_INIT) cur_init = d;
    cfg_writes++;
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  // watchdog: cycles without any transfer on any channel
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin
    int          units;
    int          sel;
    int          len;
    logic [15:0] d;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_rx_byte = 8'h00;
    cfg_valid  = 1'b0;
    cfg_index  = 2'b00;
    cfg_data   = 16'h0000;
    cur_poly   = CRC_POLY_RST;
    cur_init   = CRC_INIT_RST;
    no_idle    = 1'b0;
    hold_req   = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty frame, extreme payload bytes, bad end over bad CRC, bad CRC
    send_frame(0, 16'h0000, END_BYTE, NO_CUT);
    pl[0] = 8'hFF;
    pl[1] = 8'h00;
    send_frame(2, 16'h0000, END_BYTE, NO_CUT);
    pl[0] = START_BYTE;
    send_frame(1, 16'h0001, 8'h00, NO_CUT);
    pl[0] = 8'h55;
    send_frame(1, 16'h8000, END_BYTE, NO_CUT);
    drain();
    // a start byte that hits the hunt limit is lost
    cfg_write(REG_HUNT_LIMIT, 16'd1);
    send_byte(8'hFF);
    send_byte(START_BYTE);

    while (frame_bytes < ITEM_TARGET) begin
      drain();
      case ($urandom_range(0, 5))
        0:       d = 16'h0000;
        1:       d = 16'hFFFF;
        2:       d = 16'h1021;
        3:       d = 16'h8005;
        default: d = 16'($urandom);
      endcase
      cfg_write(REG_CRC_POLY, d);
      case ($urandom_range(0, 3))
        0:       d = 16'h0000;
        1:       d = 16'hFFFF;
        default: d = 16'($urandom);
      endcase
      cfg_write(REG_CRC_INIT, d);
      d[15:8] = 8'($urandom);
      if (phases == 0) d[7:0] = 8'd255;
      else begin
        case ($urandom_range(0, 7))
          0:       d[7:0] = 8'd0;
          1:       d[7:0] = 8'd1;
          2:       d[7:0] = 8'd255;
          3:       d[7:0] = 8'($urandom_range(2, 6));
          4:       d[7:0] = HUNT_LIMIT_RST;
          default: d[7:0] = 8'($urandom_range(8, 40));
        endcase
      end
      cfg_write(REG_HUNT_LIMIT, d);
      if (phases == 0 || $urandom_range(0, 3) == 0) cfg_write(REG_UNUSED, 16'($urandom));

      no_idle = ($urandom_range(0, 4) == 0);
      // receiver holds off while the sender keeps offering
      if (phases == 0 || $urandom_range(0, 7) == 0) hold_req = 1'b1;
      if (phases == 0) begin
        fill_payload(255);
        send_frame(255, 16'h0000, END_BYTE, NO_CUT);
      end

      units = $urandom_range(8, 20);
      repeat (units) begin
        sel = $urandom_range(0, 99);
        len = pick_len();
        fill_payload(len);
        if (sel < 70) begin
          d = ($urandom_range(0, 4) == 0) ? (16'h0001 << $urandom_range(0, 15)) : 16'h0000;
          send_frame(len, d, ($urandom_range(0, 6) == 0) ? 8'($urandom) : END_BYTE, NO_CUT);
        end else if (sel < 85) begin
          repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
        end else begin
          send_frame(len, 16'h0000, END_BYTE, $urandom_range(1, len + 4));
        end
      end
      phases++;
    end
    drain();

    $display("%0d bytes driven, %0d of them in %0d frames, %0d register writes, %0d settings",
             bytes_sent, frame_bytes, frames_sent, cfg_writes, phases + 1);
    $display("%0d results compared against the predicted stream", results_seen);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
